FILE: hw/rtl/stst_pkg.sv
// Package for the sorted top-N score table.
// Holds table size, widths, the cell control struct and the score order key.
package stst_pkg;

  localparam int unsigned Slots     = 8;
  localparam int unsigned ScoreW    = 64;
  localparam int unsigned RankW     = 3;
  localparam int unsigned SlotIdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned SlotCntW  = $clog2(Slots + 1);

  localparam logic [ScoreW-1:0] SignBit = {1'b1, {(ScoreW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DUMP
  } state_e;

  // control broadcast from the controller to each cell
  typedef struct packed {
    logic             insert;   // apply an insert this cycle
    logic             full;     // table was full before this insert
    logic [ScoreW-1:0] score;
    logic [ScoreW-1:0] key;     // order key of the new score
    logic             shift;    // rotate the row for the dump
  } cell_ctl_t;

  // map double bits to an unsigned key whose order is the score order
  function automatic logic [ScoreW-1:0] order_key(input logic [ScoreW-1:0] b);
    logic [ScoreW-1:0] t;
    t = (b == SignBit) ? '0 : b;
    if (t[ScoreW-1]) begin
      return ~t;
    end
    return t | SignBit;
  endfunction

endpackage

FILE: hw/rtl/stst_if.sv
// Valid/ready channel interfaces for the score table.
// Depends on stst_pkg for widths.
interface stst_in_if;
  logic                         valid;
  logic                         ready;
  logic [stst_pkg::ScoreW-1:0]  score_bits;
  modport source (output valid, output score_bits, input ready);
  modport sink (input valid, input score_bits, output ready);
endinterface

interface stst_out_if;
  logic                         valid;
  logic                         ready;
  logic [stst_pkg::RankW-1:0]   rank;
  logic [stst_pkg::ScoreW-1:0]  entry_bits;
  logic                         entry_valid;
  logic                         last_entry;
  modport source (output valid, output rank, output entry_bits, output entry_valid,
                  output last_entry, input ready);
  modport sink (input valid, input rank, input entry_bits, input entry_valid,
                input last_entry, output ready);
endinterface

FILE: hw/rtl/stst_cell.sv
// One slot of the sorted score row.
// Depends on stst_pkg. Takes from its upper neighbor on insert, rotates on dump.
module stst_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stst_pkg::cell_ctl_t         ctl_i,
  input  logic                        up_used_i,   // neighbor above
  input  logic [stst_pkg::ScoreW-1:0] up_score_i,
  input  logic                        up_gt_i,     // neighbor above key > new key
  input  logic                        first_empty_i, // this is highest empty slot
  input  logic                        rot_used_i,  // rotation source
  input  logic [stst_pkg::ScoreW-1:0] rot_score_i,
  output logic                        used_o,
  output logic [stst_pkg::ScoreW-1:0] score_o,
  output logic                        gt_o         // used and key > new key
);

  logic                        used_q, used_d;
  logic [stst_pkg::ScoreW-1:0] score_q, score_d;

  assign gt_o = used_q && (stst_pkg::order_key(score_q) > ctl_i.key);

  always_comb begin
    used_d  = used_q;
    score_d = score_q;
    if (ctl_i.shift) begin
      used_d  = rot_used_i;
      score_d = rot_score_i;
    end else if (ctl_i.insert) begin
      // cells from the start slot up to the insert point shift down one
      if (!gt_o && (used_q || first_empty_i || ctl_i.full)) begin
        if (up_used_i && !up_gt_i) begin
          score_d = up_score_i;
        end else begin
          score_d = ctl_i.score;
        end
        used_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      score_q <= '0;
    end else begin
      used_q  <= used_d;
      score_q <= score_d;
    end
  end

  assign used_o  = used_q;
  assign score_o = score_q;

endmodule

FILE: hw/rtl/sorted_top_n_score_table_unit.sv
// Top level of the sorted top-N score table: controller and a row of cells.
// Depends on stst_pkg, stst_if and stst_cell.
//
//  channel | dir | payload                                   | handshake
//  in_ch   | in  | score_bits                                | valid/ready
//  out_ch  | out | rank, entry_bits, entry_valid, last_entry | valid/ready
//
// An item is taken in idle, then goes through the insert state and a dump of
// Slots results; idle returns after the last result. The dump rotates the
// cell row once per result. Reset clears the table to empty. Output stalls
// hold the row; a new item is taken only after the last result of the
// current dump is taken.
module sorted_top_n_score_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  stst_in_if.sink       in_ch,
  stst_out_if.source    out_ch
);

  localparam int unsigned N = stst_pkg::Slots;

  stst_pkg::state_e            state_q, state_d;
  logic [stst_pkg::ScoreW-1:0] score_q;
  logic [stst_pkg::SlotIdxW-1:0] cnt_q, cnt_d;
  stst_pkg::cell_ctl_t         ctl;

  logic                        used   [N];
  logic [stst_pkg::ScoreW-1:0] sc     [N];
  logic                        gt     [N];
  logic                        full, take;

  assign full = used[0];
  // when full, refuse unless strictly above the lowest entry
  assign take = !full || !gt[0] &&
                (stst_pkg::order_key(sc[0]) != stst_pkg::order_key(score_q));

  always_comb begin
    ctl.insert = (state_q == stst_pkg::ST_INSERT) && take;
    ctl.full   = full;
    ctl.score  = score_q;
    ctl.key    = stst_pkg::order_key(score_q);
    ctl.shift  = (state_q == stst_pkg::ST_DUMP) && out_ch.ready;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic up_u, up_g, fe;
    logic [stst_pkg::ScoreW-1:0] up_s;
    if (g == N - 1) begin : g_top
      assign up_u = 1'b0;
      assign up_s = '0;
      assign up_g = 1'b1;
      assign fe   = !used[g];
    end else begin : g_mid
      assign up_u = used[g+1];
      assign up_s = sc[g+1];
      assign up_g = gt[g+1];
      assign fe   = !used[g] && used[g+1];
    end
    stst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .up_used_i    (up_u),
      .up_score_i   (up_s),
      .up_gt_i      (up_g),
      .first_empty_i(fe),
      .rot_used_i   (used[(g + 1) % N]),
      .rot_score_i  (sc[(g + 1) % N]),
      .used_o       (used[g]),
      .score_o      (sc[g]),
      .gt_o         (gt[g])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      stst_pkg::ST_IDLE: begin
        if (in_ch.valid) state_d = stst_pkg::ST_INSERT;
      end
      stst_pkg::ST_INSERT: begin
        state_d = stst_pkg::ST_DUMP;
        cnt_d   = '0;
      end
      stst_pkg::ST_DUMP: begin
        if (out_ch.ready) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == stst_pkg::SlotIdxW'(N - 1)) state_d = stst_pkg::ST_IDLE;
        end
      end
      default: state_d = stst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stst_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) score_q <= in_ch.score_bits;
  end

  assign in_ch.ready        = (state_q == stst_pkg::ST_IDLE);
  assign out_ch.valid       = (state_q == stst_pkg::ST_DUMP);
  assign out_ch.rank        = stst_pkg::RankW'(cnt_q);
  assign out_ch.entry_bits  = used[0] ? sc[0] : '0;
  assign out_ch.entry_valid = used[0];
  assign out_ch.last_entry  = (cnt_q == stst_pkg::SlotIdxW'(N - 1));

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != stst_pkg::ST_IDLE) |-> !in_ch.ready) else $error("busy accept");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && out_ch.last_entry) |=>
    (state_q == stst_pkg::ST_IDLE)) else $error("dump overrun");
  a_fill_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stst_pkg::ST_IDLE && used[0]) |-> used[N-1]) else $error("fill order");
`endif

endmodule
